// ===== sv/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, codes and constants of the shortest path core.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int NODES_DEF = 1024;
    localparam int EDGES_DEF = 4096;
    localparam int DIST_W    = 48;
    localparam int CFG_W     = 11;
    localparam int FNODE_W   = 10;
    localparam int WEIGHT_W  = 32;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int CFG_MAX   = 2047;

    localparam logic [DIST_W-1:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;

    // register addresses
    localparam logic [APB_AW-1:0] ADDR_NODE_COUNT = 3'd0;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_e;

    typedef struct packed {
        logic [1:0]          command;
        logic [FNODE_W-1:0]  edge_tail;
        logic [FNODE_W-1:0]  edge_head;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [FNODE_W-1:0]  source_node;
        logic [FNODE_W-1:0]  query_node;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              reachable;
        logic [DIST_W-1:0] distance;
    } rsp_t;

    typedef struct packed {
        logic [FNODE_W-1:0]  tail;
        logic [FNODE_W-1:0]  head;
        logic [WEIGHT_W-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic              settled;
        logic              reach;
        logic [DIST_W-1:0] cost;
    } node_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_SETTLE,
        S_E_ISSUE,
        S_E_WAIT,
        S_E_CHECK,
        S_READ_WAIT,
        S_RUN_END
    } state_e;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic load_out;
        logic read_done;
        logic init_step;
        logic scan_start;
        logic scan_issue;
        logic settle;
        logic edge_issue;
        logic edge_check;
        logic relax;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       src_ok;
        logic       out_free;
        logic       init_last;
        logic       scan_done;
        logic       found;
        logic       edge_done;
        logic       edge_hit;
    } sts_t;

endpackage

// ===== sv/single_source_shortest_path_core.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_path_core
// Shortest path distances from one source node over a loaded edge list.
// ----------------------------------------------------------------------------
// Clear and add-edge requests are answered from the idle state; a read
// first waits for the node table read. A run first sweeps the whole node
// table, one node per cycle, and then for each reachable node settles it
// after a linear minimum scan over the nodes in use, followed by a walk
// over every stored edge that relaxes each edge leaving the settled node
// whose head is in range. The node table memory has a single write and a
// single read port. The block accepts no request while a run is in
// progress.
module single_source_shortest_path_core #(
    parameter int NODES = ssp_pkg::NODES_DEF,
    parameter int EDGES = ssp_pkg::EDGES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  ssp_pkg::req_t              in_req,
    output logic                       out_valid,
    input  logic                       out_stall,
    output ssp_pkg::rsp_t              out_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssp_pkg::APB_AW-1:0] paddr,
    input  logic [ssp_pkg::APB_DW-1:0] pwdata,
    output logic [ssp_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import ssp_pkg::*;

    localparam int CFG_RST = (NODES > CFG_MAX) ? CFG_MAX : NODES;

    logic [CFG_W-1:0] node_count_reg;
    ctl_t             ctl;
    sts_t             sts;
    logic             ready;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CFG_W'(CFG_RST);
        end
        else if (psel && penable && pwrite && (paddr == ADDR_NODE_COUNT))
        begin
            node_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_NODE_COUNT) ? APB_DW'(node_count_reg) : '0;

    // controller and datapath
    ssp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .ctl      (ctl),
        .ready    (ready)
    );

    ssp_datapath #(
        .NODES (NODES),
        .EDGES (EDGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_count (node_count_reg),
        .in_req     (in_req),
        .ctl        (ctl),
        .sts        (sts),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_rsp    (out_rsp)
    );

    assign in_stall = !ready;

`ifndef ASSERT_OFF
    // a request is only taken when the response slot is free
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (!out_valid || !out_stall))
        else $error("request taken while response blocked");

    // a non-zero distance always comes with the reachable flag
    a_dist_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_rsp.distance != '0)) |-> out_rsp.reachable)
        else $error("distance without reachable");

    // a rejected request never reports a reachable node
    a_err_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_rsp.status != ST_OK)) |-> !out_rsp.reachable)
        else $error("reachable on error status");

    // a response load is never directly followed by one without a request
    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |=> !(ctl.load_out && !ctl.take))
        else $error("two responses without a request");
`endif

endmodule

// ===== sv/ssp_ram.sv =====
// ----------------------------------------------------------------------------
// ssp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ssp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer for request intake, run initialisation, minimum scan and relaxation.
// ----------------------------------------------------------------------------
module ssp_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  ssp_pkg::sts_t sts,
    output ssp_pkg::ctl_t ctl,
    output logic         ready
);
    import ssp_pkg::*;

    state_e state_reg;
    state_e state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ready    = sts.out_free;
                ctl.take = sts.out_free && in_valid;
                if (ctl.take)
                begin
                    case (sts.cmd)
                        CMD_RUN:
                        begin
                            if (sts.src_ok)
                            begin
                                state_next = S_INIT;
                            end
                            else
                            begin
                                ctl.load_out = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            state_next = S_READ_WAIT;
                        end
                        default:
                        begin
                            ctl.load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                ctl.init_step = 1'b1;
                if (sts.init_last)
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_issue = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = sts.found ? S_SETTLE : S_RUN_END;
                end
            end
            S_SETTLE:
            begin
                ctl.settle = 1'b1;
                state_next = S_E_ISSUE;
            end
            S_E_ISSUE:
            begin
                if (sts.edge_done)
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    ctl.edge_issue = 1'b1;
                    state_next     = S_E_WAIT;
                end
            end
            S_E_WAIT:
            begin
                if (sts.edge_hit)
                begin
                    ctl.edge_check = 1'b1;
                    state_next     = S_E_CHECK;
                end
                else
                begin
                    state_next = S_E_ISSUE;
                end
            end
            S_E_CHECK:
            begin
                ctl.relax  = 1'b1;
                state_next = S_E_ISSUE;
            end
            S_READ_WAIT:
            begin
                ctl.load_out  = 1'b1;
                ctl.read_done = 1'b1;
                state_next    = S_IDLE;
            end
            S_RUN_END:
            begin
                ctl.load_out = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ssp_datapath.sv =====
// ----------------------------------------------------------------------------
// ssp_datapath
// Edge store, node table, scan and relaxation arithmetic, response register.
// ----------------------------------------------------------------------------
module ssp_datapath #(
    parameter int NODES = 1024,
    parameter int EDGES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ssp_pkg::CFG_W-1:0]   node_count,
    input  ssp_pkg::req_t               in_req,
    input  ssp_pkg::ctl_t               ctl,
    output ssp_pkg::sts_t               sts,
    input  logic                        out_stall,
    output logic                        out_valid,
    output ssp_pkg::rsp_t               out_rsp
);
    import ssp_pkg::*;

    localparam int NIW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int EIW = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int ECW = $clog2(EDGES + 1);
    localparam int NCW = ($clog2(NODES + 1) > CFG_W) ? $clog2(NODES + 1) : CFG_W;

    logic [NCW-1:0]    n_act;
    logic [ECW-1:0]    edges_reg;
    logic [NIW-1:0]    src_reg;
    logic              qry_bad_reg;
    logic              ran_reg;
    logic [NCW-1:0]    cnt_reg;
    logic              pv_reg;
    logic [NIW-1:0]    pidx_reg;
    logic              found_reg;
    logic [NIW-1:0]    best_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [ECW-1:0]    e_reg;
    logic [DIST_W-1:0] sum_reg;
    logic [NIW-1:0]    head_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic              n_we;
    logic [NIW-1:0]    n_waddr;
    node_t             n_wdata;
    logic [NIW-1:0]    n_raddr;
    node_t             n_rdata;
    logic              e_we;
    edge_t             e_wdata;
    edge_t             e_rdata;

    logic              tail_ok;
    logic              head_ok;
    logic              src_ok;
    logic              store_full;
    logic              cand;
    logic [DIST_W:0]   sum_wide;
    rsp_t              rsp_now;
    rsp_t              rsp_read;

    // nodes in use, clamped to the range 1 to the table size
    always_comb
    begin
        if (node_count == '0)
        begin
            n_act = NCW'(1);
        end
        else if (NCW'(node_count) > NCW'(NODES))
        begin
            n_act = NCW'(NODES);
        end
        else
        begin
            n_act = NCW'(node_count);
        end
    end

    // range and capacity checks of the incoming request
    assign tail_ok    = NCW'(in_req.edge_tail) < n_act;
    assign head_ok    = NCW'(in_req.edge_head) < n_act;
    assign src_ok     = NCW'(in_req.source_node) < n_act;
    assign store_full = edges_reg == ECW'(EDGES);

    // edge store
    assign e_we    = ctl.take && (in_req.command == CMD_ADD) && tail_ok && head_ok && !store_full;
    assign e_wdata = '{tail: in_req.edge_tail, head: in_req.edge_head, weight: in_req.edge_weight};

    ssp_ram #(
        .WIDTH ($bits(edge_t)),
        .DEPTH (EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (EIW'(edges_reg)),
        .wdata (e_wdata),
        .raddr (EIW'(e_reg)),
        .rdata (e_rdata)
    );

    // node table write and read selection
    always_comb
    begin
        n_we    = 1'b0;
        n_waddr = NIW'(cnt_reg);
        n_wdata = '0;
        if (ctl.init_step)
        begin
            n_we          = 1'b1;
            n_wdata.reach = NIW'(cnt_reg) == src_reg;
        end
        else if (ctl.settle)
        begin
            n_we    = 1'b1;
            n_waddr = best_reg;
            n_wdata = '{settled: 1'b1, reach: 1'b1, cost: best_dist_reg};
        end
        else if (ctl.relax)
        begin
            n_waddr = head_reg;
            n_wdata = '{settled: n_rdata.settled, reach: 1'b1, cost: sum_reg};
            n_we    = !n_rdata.reach || (sum_reg < n_rdata.cost);
        end
    end

    always_comb
    begin
        if (ctl.take)
        begin
            n_raddr = NIW'(in_req.query_node);
        end
        else if (ctl.edge_check)
        begin
            n_raddr = NIW'(e_rdata.head);
        end
        else
        begin
            n_raddr = NIW'(cnt_reg);
        end
    end

    ssp_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    // scan candidate and saturating path sum
    assign cand     = pv_reg && n_rdata.reach && !n_rdata.settled
                      && (!found_reg || (n_rdata.cost < best_dist_reg));
    assign sum_wide = {1'b0, best_dist_reg} + (DIST_W + 1)'(e_rdata.weight);

    // run and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_reg <= '0;
            ran_reg   <= 1'b0;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            found_reg <= 1'b0;
            e_reg     <= '0;
        end
        else
        begin
            if (ctl.take)
            begin
                case (in_req.command)
                    CMD_CLEAR:
                    begin
                        edges_reg <= '0;
                    end
                    CMD_ADD:
                    begin
                        if (e_we)
                        begin
                            edges_reg <= edges_reg + ECW'(1);
                        end
                    end
                    CMD_RUN:
                    begin
                        cnt_reg <= '0;
                        if (src_ok)
                        begin
                            ran_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.init_step)
            begin
                cnt_reg <= cnt_reg + NCW'(1);
            end
            if (ctl.scan_start)
            begin
                cnt_reg   <= '0;
                pv_reg    <= 1'b0;
                found_reg <= 1'b0;
            end
            if (ctl.scan_issue)
            begin
                pv_reg <= cnt_reg < n_act;
                if (cnt_reg < n_act)
                begin
                    cnt_reg <= cnt_reg + NCW'(1);
                end
                if (cand)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ctl.settle)
            begin
                e_reg <= '0;
            end
            if (ctl.edge_issue)
            begin
                e_reg <= e_reg + ECW'(1);
            end
        end
    end

    // payload registers of the run
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            src_reg     <= NIW'(in_req.source_node);
            qry_bad_reg <= !(NCW'(in_req.query_node) < n_act);
        end
        if (ctl.scan_issue)
        begin
            pidx_reg <= NIW'(cnt_reg);
            if (cand)
            begin
                best_reg      <= pidx_reg;
                best_dist_reg <= n_rdata.cost;
            end
        end
        if (ctl.edge_check)
        begin
            sum_reg  <= sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
            head_reg <= NIW'(e_rdata.head);
        end
    end

    // immediate and read responses
    always_comb
    begin
        rsp_now = '0;
        case (in_req.command)
            CMD_ADD:
            begin
                if (!tail_ok || !head_ok)
                begin
                    rsp_now.status = ST_RANGE;
                end
                else if (store_full)
                begin
                    rsp_now.status = ST_FULL;
                end
            end
            CMD_RUN:
            begin
                if (!src_ok)
                begin
                    rsp_now.status = ST_RANGE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_read = '0;
        if (qry_bad_reg)
        begin
            rsp_read.status = ST_RANGE;
        end
        else if (ran_reg && n_rdata.reach)
        begin
            rsp_read.reachable = 1'b1;
            rsp_read.distance  = n_rdata.cost;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            if (ctl.read_done)
            begin
                out_reg <= rsp_read;
            end
            else if (ctl.take)
            begin
                out_reg <= rsp_now;
            end
            else
            begin
                out_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    // status towards the controller
    assign sts.cmd       = in_req.command;
    assign sts.src_ok    = src_ok;
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign sts.init_last = cnt_reg == NCW'(NODES - 1);
    assign sts.scan_done = (cnt_reg == n_act) && !pv_reg;
    assign sts.found     = found_reg;
    assign sts.edge_done = e_reg == edges_reg;
    assign sts.edge_hit  = (NCW'(e_rdata.tail) == NCW'(best_reg)) && (NCW'(e_rdata.head) < n_act);

endmodule

// ===== tb/single_source_shortest_path_core_test.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_path_core_test
// Self-checking bench for the shortest path core.
// ----------------------------------------------------------------------------
// Loads small graphs, runs searches from chosen sources and reads distances
// back. A scoreboard class keeps its own edge list and distance table, works
// out the response to each accepted request and checks each response field
// by field. The request side idles and the response side stalls at random,
// and the node count is changed between phases, extremes included.
// ----------------------------------------------------------------------------
import ssp_pkg::*;

class path_scoreboard;
    bit [FNODE_W-1:0]  tails [EDGES_DEF];
    bit [FNODE_W-1:0]  heads [EDGES_DEF];
    bit [WEIGHT_W-1:0] weights [EDGES_DEF];
    int unsigned       edges_loaded;
    bit [DIST_W-1:0]   node_dist [NODES_DEF];
    bit                reach [NODES_DEF];
    bit                settled [NODES_DEF];
    int unsigned       node_count;
    rsp_t              expected_q [$];
    int                mismatches;
    int                checked;

    function new();
        edges_loaded = 0;
        node_count   = NODES_DEF;
        mismatches   = 0;
        checked      = 0;
        foreach (reach[i])
        begin
            reach[i]     = 1'b0;
            settled[i]   = 1'b0;
            node_dist[i] = '0;
        end
    endfunction

    // register write, clamped to 1..NODES
    function void set_node_count(bit [CFG_W-1:0] value);
        if (value == 0)
            node_count = 1;
        else if (value > NODES_DEF)
            node_count = NODES_DEF;
        else
            node_count = 32'(value);
    endfunction

    // dijkstra with a linear minimum scan, lowest index wins ties
    function void search_from(int unsigned src);
        int unsigned     u;
        int unsigned     v;
        bit              found;
        bit [63:0]       sum;
        foreach (reach[i])
        begin
            reach[i]     = 1'b0;
            settled[i]   = 1'b0;
            node_dist[i] = '0;
        end
        reach[src] = 1'b1;
        forever
        begin
            found = 1'b0;
            u     = 0;
            for (int i = 0; i < node_count; i++)
                if (reach[i] && !settled[i] && (!found || node_dist[i] < node_dist[u]))
                begin
                    u     = i;
                    found = 1'b1;
                end
            if (!found)
                break;
            settled[u] = 1'b1;
            for (int e = 0; e < edges_loaded; e++)
            begin
                v = 32'(heads[e]);
                if (tails[e] != u || v >= node_count)
                    continue;
                sum = {16'd0, node_dist[u]} + {32'd0, weights[e]};
                if (sum > {16'd0, DIST_MAX})
                    sum = {16'd0, DIST_MAX};
                if (!reach[v] || sum[DIST_W-1:0] < node_dist[v])
                begin
                    node_dist[v] = sum[DIST_W-1:0];
                    reach[v]     = 1'b1;
                end
            end
        end
    endfunction

    // accepted request: update state and queue the expected response
    function void note_request(req_t r);
        rsp_t exp_rsp;
        exp_rsp = '0;
        exp_rsp.status = ST_OK;
        case (r.command)
            CMD_CLEAR:
                edges_loaded = 0;
            CMD_ADD:
                if (r.edge_tail >= node_count || r.edge_head >= node_count)
                    exp_rsp.status = ST_RANGE;
                else if (edges_loaded >= EDGES_DEF)
                    exp_rsp.status = ST_FULL;
                else
                begin
                    tails[edges_loaded]   = r.edge_tail;
                    heads[edges_loaded]   = r.edge_head;
                    weights[edges_loaded] = r.edge_weight;
                    edges_loaded++;
                end
            CMD_RUN:
                if (r.source_node >= node_count)
                    exp_rsp.status = ST_RANGE;
                else
                    search_from(32'(r.source_node));
            default:
                if (r.query_node >= node_count)
                    exp_rsp.status = ST_RANGE;
                else if (reach[r.query_node])
                begin
                    exp_rsp.reachable = 1'b1;
                    exp_rsp.distance  = node_dist[r.query_node];
                end
        endcase
        expected_q.push_back(exp_rsp);
    endfunction

    // accepted response: compare with the oldest expectation
    function void check_result(rsp_t got);
        rsp_t exp_rsp;
        checked++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response: status %0d reach %0d dist %0h",
                         got.status, got.reachable, got.distance);
            return;
        end
        exp_rsp = expected_q.pop_front();
        if (got.status !== exp_rsp.status || got.reachable !== exp_rsp.reachable ||
            got.distance !== exp_rsp.distance)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("response %0d: expected status %0d reach %0d dist %0h, got %0d %0d %0h",
                         checked, exp_rsp.status, exp_rsp.reachable, exp_rsp.distance,
                         got.status, got.reachable, got.distance);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module single_source_shortest_path_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    req_t                in_req;
    logic                out_valid;
    logic                out_stall;
    rsp_t                out_rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    path_scoreboard sb;
    bit             calm;
    int             stall_left;
    int             requests_sent;
    int             runs_sent;

    single_source_shortest_path_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

    // response side: check and stall at random
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_result(out_rsp);
                stall_left = calm ? 0 : $urandom_range(0, 5);
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // one request, with a random gap in front of it
    task automatic send_request(req_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(r);
        requests_sent++;
        if (r.command == CMD_RUN)
            runs_sent++;
    endtask

    // request with every field random, then the chosen ones set
    function automatic req_t random_request();
        logic [95:0] noise;
        req_t        r;
        noise = {$urandom, $urandom, $urandom};
        r     = noise[$bits(req_t)-1:0];
        return r;
    endfunction

    task automatic do_clear();
        req_t r;
        r = random_request();
        r.command = CMD_CLEAR;
        send_request(r);
    endtask

    task automatic do_add(int unsigned tail, int unsigned head, bit [31:0] w);
        req_t r;
        r = random_request();
        r.command     = CMD_ADD;
        r.edge_tail   = FNODE_W'(tail);
        r.edge_head   = FNODE_W'(head);
        r.edge_weight = w;
        send_request(r);
    endtask

    task automatic do_run(int unsigned src);
        req_t r;
        r = random_request();
        r.command     = CMD_RUN;
        r.source_node = FNODE_W'(src);
        send_request(r);
    endtask

    task automatic do_read(int unsigned node);
        req_t r;
        r = random_request();
        r.command    = CMD_READ;
        r.query_node = FNODE_W'(node);
        send_request(r);
    endtask

    // wait for every response, then let the core settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // register write while idle
    task automatic write_node_count(bit [CFG_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NODE_COUNT;
        pwdata  <= {{(APB_DW-CFG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_node_count(value);
    endtask

    function automatic bit [31:0] random_weight();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // main sequence
    initial
    begin
        bit [CFG_W-1:0] n_cfg;
        int unsigned    n;
        int             edge_total;
        sb            = new();
        calm          = 1'b0;
        requests_sent = 0;
        runs_sent     = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_req   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: read before a run, extreme weights, stale edges, clamping
        do_read(5);
        do_read(1023);
        do_clear();
        do_add(0, 1, 32'd0);
        do_add(1, 2, 32'hFFFF_FFFF);
        do_add(2, 1, 32'd1);
        do_add(1023, 0, 32'hFFFF_FFFF);
        do_add(0, 1023, 32'h8000_0000);
        do_run(0);
        do_read(0);
        do_read(1);
        do_read(2);
        do_read(1023);
        do_read(3);
        write_node_count(11'd3);
        do_run(1023);
        do_add(1023, 0, 32'd7);
        do_add(0, 1023, 32'd7);
        do_run(2);
        do_read(1023);
        do_read(1);
        do_read(0);
        write_node_count(11'd0);
        do_run(0);
        do_read(0);
        do_read(1);
        write_node_count(11'd2047);
        do_run(1023);
        do_read(0);

        // random phases: small graphs, some stale edges and noise
        for (int phase = 0; phase < 15; phase++)
        begin
            case ($urandom_range(0, 9))
                0: n_cfg = (phase % 2) ? 11'd1024 : 11'd2047;
                1: n_cfg = CFG_W'($urandom_range(0, 2));
                2: n_cfg = CFG_W'($urandom_range(1025, 2047));
                default: n_cfg = CFG_W'($urandom_range(3, 32));
            endcase
            if (phase == 3)
                n_cfg = 11'd1;
            write_node_count(n_cfg);
            n    = sb.node_count;
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                do_clear();
            edge_total = $urandom_range(5, 22);
            for (int k = 0; k < edge_total; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    do_add($urandom_range(0, 1023), $urandom_range(0, 1023),
                           random_weight());
                else
                    do_add($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                           random_weight());
            end
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    do_run($urandom_range(0, 1023));
                else
                    do_run($urandom_range(0, n - 1));
                for (int j = 0; j < 10; j++)
                    if ($urandom_range(0, 7) == 0)
                        do_read($urandom_range(0, 1023));
                    else
                        do_read($urandom_range(0, n - 1));
                if (phase == 6 && k == 1)
                    drain();
            end
        end

        // small graph with out-of-range edges, then a clear and a fresh edge
        write_node_count(11'd4);
        calm = 1'b0;
        do_clear();
        do_add(0, 1, 32'd5);
        do_add(1, 2, 32'd7);
        do_add(2, 3, 32'd1);
        do_add(0, 3, 32'd20);
        do_add(3, 1023, 32'd1);
        do_add(3, 0, 32'd1);
        do_run(0);
        for (int k = 0; k < 4; k++)
            do_read(k);
        do_clear();
        do_add(3, 0, 32'd2);
        do_run(3);
        do_read(0);
        do_read(1);

        drain();
        repeat (50) @(posedge clk);
        $display("%0d requests sent, %0d of them searches; %0d responses checked",
                 requests_sent, runs_sent, sb.checked);
        $display("node counts from 1 up to past the table, stale and out-of-range edges");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
